@@ hdl/dd_odom_pkg.sv @@
// ----------------------------------------------------------------------------
// dd_odom_pkg
// Shared types, constants and tables for the wheel odometry block.
// ----------------------------------------------------------------------------
package dd_odom_pkg;

  // CORDIC iteration count (8..24)
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_STEPS    = 64;
  localparam int unsigned CNT_W        = 7;

  // CORDIC start gain, Q2.30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  // microseconds per second
  localparam logic [19:0] USEC = 20'd1000000;

  // register indices (address bits [3:2])
  localparam logic [1:0] REG_INVERT = 2'd0;
  localparam logic [1:0] REG_DIST   = 2'd1;
  localparam logic [1:0] REG_HEAD   = 2'd2;

  typedef struct packed {
    logic signed [31:0] raw_right;
    logic signed [31:0] raw_left;
    logic        [31:0] time_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_rate;
    logic signed [31:0] delta_right;
    logic signed [31:0] delta_left;
  } out_t;

  typedef struct packed {
    logic        invert_right;
    logic [23:0] dist_per_tick_q24;
    logic [25:0] heading_per_tick;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_FIRST, OP_DELTA, OP_MUL, OP_HEAD, OP_CINIT, OP_CSTEP,
    OP_PX, OP_PY, OP_QUAT, OP_PLO, OP_PHI, OP_DINIT, OP_DSTEP, OP_DFIN, OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DELTA, S_MUL, S_HEAD, S_C1INIT, S_C1STEP, S_PX, S_PY,
    S_C2INIT, S_C2STEP, S_QUAT, S_PLO, S_PHI, S_DINIT, S_DSTEP, S_DFIN, S_DONE
  } state_e;

  typedef struct packed {
    op_e              op;
    logic             sel;   // half-angle CORDIC / angular division
    logic [CNT_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic dt_zero;
  } stat_t;

  // arctangent table, 2^-32 turn units
  function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:  a = 34'sh020000000;
      5'd1:  a = 34'sh012E4051E;
      5'd2:  a = 34'sh009FB385B;
      5'd3:  a = 34'sh0051111D4;
      5'd4:  a = 34'sh0028B0D43;
      5'd5:  a = 34'sh00145D7E1;
      5'd6:  a = 34'sh000A2F61E;
      5'd7:  a = 34'sh000517C55;
      5'd8:  a = 34'sh00028BE53;
      5'd9:  a = 34'sh000145F2F;
      5'd10: a = 34'sh0000A2F98;
      5'd11: a = 34'sh0000517CC;
      5'd12: a = 34'sh000028BE6;
      5'd13: a = 34'sh0000145F3;
      5'd14: a = 34'sh00000A2FA;
      5'd15: a = 34'sh00000517D;
      5'd16: a = 34'sh0000028BE;
      5'd17: a = 34'sh00000145F;
      5'd18: a = 34'sh000000A30;
      5'd19: a = 34'sh000000518;
      5'd20: a = 34'sh00000028C;
      5'd21: a = 34'sh000000146;
      5'd22: a = 34'sh0000000A3;
      5'd23: a = 34'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hdl/dd_odom_ctrl.sv @@
// ----------------------------------------------------------------------------
// dd_odom_ctrl
// Sequencer for the odometry datapath and owner of the result handshake.
// ----------------------------------------------------------------------------
module dd_odom_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  dd_odom_pkg::stat_t  stat_i,
  output dd_odom_pkg::cmd_t   cmd_o
);

  dd_odom_pkg::state_e state_q, state_d;
  logic [dd_odom_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic div_q, div_d;
  logic out_valid_q, out_valid_d;
  logic accept, out_free, cordic_last, div_last;

  assign accept      = in_valid_i && (state_q == dd_odom_pkg::S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cordic_last = cnt_q == dd_odom_pkg::CNT_W'(dd_odom_pkg::CORDIC_STEPS - 1);
  assign div_last    = cnt_q == dd_odom_pkg::CNT_W'(dd_odom_pkg::DIV_STEPS - 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dd_odom_pkg::S_IDLE:   if (accept) state_d = dd_odom_pkg::S_CHECK;
      dd_odom_pkg::S_CHECK: begin
        if (stat_i.first || stat_i.dt_zero) state_d = dd_odom_pkg::S_IDLE;
        else state_d = dd_odom_pkg::S_DELTA;
      end
      dd_odom_pkg::S_DELTA:  state_d = dd_odom_pkg::S_MUL;
      dd_odom_pkg::S_MUL:    state_d = dd_odom_pkg::S_HEAD;
      dd_odom_pkg::S_HEAD:   state_d = dd_odom_pkg::S_C1INIT;
      dd_odom_pkg::S_C1INIT: state_d = dd_odom_pkg::S_C1STEP;
      dd_odom_pkg::S_C1STEP: if (cordic_last) state_d = dd_odom_pkg::S_PX;
      dd_odom_pkg::S_PX:     state_d = dd_odom_pkg::S_PY;
      dd_odom_pkg::S_PY:     state_d = dd_odom_pkg::S_C2INIT;
      dd_odom_pkg::S_C2INIT: state_d = dd_odom_pkg::S_C2STEP;
      dd_odom_pkg::S_C2STEP: if (cordic_last) state_d = dd_odom_pkg::S_QUAT;
      dd_odom_pkg::S_QUAT:   state_d = dd_odom_pkg::S_PLO;
      dd_odom_pkg::S_PLO:    state_d = dd_odom_pkg::S_PHI;
      dd_odom_pkg::S_PHI:    state_d = dd_odom_pkg::S_DINIT;
      dd_odom_pkg::S_DINIT:  state_d = dd_odom_pkg::S_DSTEP;
      dd_odom_pkg::S_DSTEP:  if (div_last) state_d = dd_odom_pkg::S_DFIN;
      dd_odom_pkg::S_DFIN: begin
        state_d = div_q ? dd_odom_pkg::S_DONE : dd_odom_pkg::S_PLO;
      end
      dd_odom_pkg::S_DONE:   if (out_free) state_d = dd_odom_pkg::S_IDLE;
      default:               state_d = dd_odom_pkg::S_IDLE;
    endcase
  end

  // counters, pass flag and result valid
  always_comb begin
    cnt_d = '0;
    if (state_q == dd_odom_pkg::S_C1STEP || state_q == dd_odom_pkg::S_C2STEP ||
        state_q == dd_odom_pkg::S_DSTEP) begin
      cnt_d = cnt_q + 1'b1;
    end
    div_d = div_q;
    if (state_q == dd_odom_pkg::S_IDLE) div_d = 1'b0;
    else if (state_q == dd_odom_pkg::S_DFIN) div_d = 1'b1;
    out_valid_d = out_valid_q;
    if (state_q == dd_odom_pkg::S_DONE && out_free) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  // datapath commands
  always_comb begin
    cmd_o.op   = dd_odom_pkg::OP_NONE;
    cmd_o.sel  = div_q || state_q == dd_odom_pkg::S_C2INIT ||
                 state_q == dd_odom_pkg::S_C2STEP;
    cmd_o.step = cnt_q;
    case (state_q)
      dd_odom_pkg::S_IDLE:   if (accept) cmd_o.op = dd_odom_pkg::OP_LOAD;
      dd_odom_pkg::S_CHECK: begin
        if (stat_i.first) cmd_o.op = dd_odom_pkg::OP_FIRST;
        else if (!stat_i.dt_zero) cmd_o.op = dd_odom_pkg::OP_DELTA;
      end
      dd_odom_pkg::S_DELTA:  cmd_o.op = dd_odom_pkg::OP_MUL;
      dd_odom_pkg::S_MUL:    cmd_o.op = dd_odom_pkg::OP_HEAD;
      dd_odom_pkg::S_C1INIT,
      dd_odom_pkg::S_C2INIT: cmd_o.op = dd_odom_pkg::OP_CINIT;
      dd_odom_pkg::S_C1STEP,
      dd_odom_pkg::S_C2STEP: cmd_o.op = dd_odom_pkg::OP_CSTEP;
      dd_odom_pkg::S_PX:     cmd_o.op = dd_odom_pkg::OP_PX;
      dd_odom_pkg::S_PY:     cmd_o.op = dd_odom_pkg::OP_PY;
      dd_odom_pkg::S_QUAT:   cmd_o.op = dd_odom_pkg::OP_QUAT;
      dd_odom_pkg::S_PLO:    cmd_o.op = dd_odom_pkg::OP_PLO;
      dd_odom_pkg::S_PHI:    cmd_o.op = dd_odom_pkg::OP_PHI;
      dd_odom_pkg::S_DINIT:  cmd_o.op = dd_odom_pkg::OP_DINIT;
      dd_odom_pkg::S_DSTEP:  cmd_o.op = dd_odom_pkg::OP_DSTEP;
      dd_odom_pkg::S_DFIN:   cmd_o.op = dd_odom_pkg::OP_DFIN;
      dd_odom_pkg::S_DONE:   if (out_free) cmd_o.op = dd_odom_pkg::OP_OUT;
      default:               cmd_o.op = dd_odom_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o  = state_q != dd_odom_pkg::S_IDLE;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dd_odom_pkg::S_IDLE;
      cnt_q       <= '0;
      div_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      div_q       <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/dd_odom_dp.sv @@
// ----------------------------------------------------------------------------
// dd_odom_dp
// Odometry datapath: deltas, products, iterative CORDIC and divider, result
// register.
// ----------------------------------------------------------------------------
module dd_odom_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dd_odom_pkg::cfg_t  cfg_i,
  input  dd_odom_pkg::in_t   in_data_i,
  input  dd_odom_pkg::cmd_t  cmd_i,
  output dd_odom_pkg::stat_t stat_o,
  output dd_odom_pkg::out_t  out_data_o
);

  // control state
  logic started_q;
  // payload
  logic [31:0] r_q, l_q, t_q, prev_r_q, prev_l_q, prev_t_q;
  logic [31:0] dr_q, dl_q, dt_q, head_q;
  logic signed [31:0] dist_q;
  logic signed [59:0] dth_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic flip_q;
  logic [47:0] acc_x_q, acc_y_q;
  logic signed [15:0] qz_q, qw_q;
  logic [58:0] mag_q;
  logic neg_q;
  logic [79:0] prod_q;
  logic [63:0] num_q;
  logic [31:0] rem_q, quo_q;
  logic ovf_q;
  logic signed [31:0] speed_q, rate_q;
  dd_odom_pkg::out_t out_q;

  assign stat_o.first   = !started_q;
  assign stat_o.dt_zero = (t_q - prev_t_q) == 32'd0;
  assign out_data_o     = out_q;

  // products of the count deltas
  logic signed [32:0] sum_v, diff_v;
  logic signed [57:0] dprod_v;
  logic signed [48:0] dshift_v;
  logic signed [31:0] dist_v;
  assign sum_v    = {dr_q[31], dr_q} + {dl_q[31], dl_q};
  assign diff_v   = {dr_q[31], dr_q} - {dl_q[31], dl_q};
  assign dprod_v  = sum_v * $signed({1'b0, cfg_i.dist_per_tick_q24});
  assign dshift_v = 49'((dprod_v + 58'sd256) >>> 9);
  always_comb begin
    if (dshift_v > 49'sh0007FFFFFFF)       dist_v = 32'sh7FFFFFFF;
    else if (dshift_v < -49'sh00080000000) dist_v = 32'sh80000000;
    else                                   dist_v = dshift_v[31:0];
  end

  // CORDIC fold and step
  logic [31:0] ang_v;
  logic signed [33:0] za_v, zi_v, xs_v, ys_v, atan_v, cos_v, sin_v;
  logic fold_v;
  assign ang_v  = cmd_i.sel ? {1'b0, head_q[31:1]} : head_q;
  assign za_v   = {{2{ang_v[31]}}, ang_v};
  assign xs_v   = cx_q >>> cmd_i.step[4:0];
  assign ys_v   = cy_q >>> cmd_i.step[4:0];
  assign atan_v = dd_odom_pkg::atan_turn(cmd_i.step[4:0]);
  assign cos_v  = flip_q ? -cx_q : cx_q;
  assign sin_v  = flip_q ? -cy_q : cy_q;
  always_comb begin
    fold_v = 1'b1;
    if (za_v > 34'sh040000000)       zi_v = za_v - 34'sh080000000;
    else if (za_v < -34'sh040000000) zi_v = za_v + 34'sh080000000;
    else begin
      zi_v   = za_v;
      fold_v = 1'b0;
    end
  end

  // position step, shared multiplier
  logic signed [65:0] pprod_v, pshift_v;
  assign pprod_v  = dist_q * ((cmd_i.op == dd_odom_pkg::OP_PY) ? sin_v : cos_v);
  assign pshift_v = (pprod_v + 66'sd536870912) >>> 30;

  // quaternion rounding
  logic signed [33:0] qzs_v, qws_v;
  logic signed [15:0] qz_v, qw_v;
  assign qzs_v = (sin_v + 34'sd16384) >>> 15;
  assign qws_v = (cos_v + 34'sd16384) >>> 15;
  always_comb begin
    if (qzs_v > 34'sd32767)       qz_v = 16'sh7FFF;
    else if (qzs_v < -34'sd32768) qz_v = 16'sh8000;
    else                          qz_v = qzs_v[15:0];
    if (qws_v > 34'sd32767)       qw_v = 16'sh7FFF;
    else if (qws_v < -34'sd32768) qw_v = 16'sh8000;
    else                          qw_v = qws_v[15:0];
  end

  // divider operand and step
  logic signed [59:0] sabs_v;
  logic [58:0] mag_v;
  logic neg_v;
  logic [32:0] rem2_v;
  logic ge_v;
  logic [31:0] res_v;
  always_comb begin
    sabs_v = cmd_i.sel ? dth_q : 60'(dist_q);
    neg_v  = sabs_v[59];
    mag_v  = neg_v ? 59'(-sabs_v) : sabs_v[58:0];
  end
  assign rem2_v = {rem_q, num_q[63]};
  assign ge_v   = rem2_v >= {1'b0, dt_q};
  always_comb begin
    if (neg_q) res_v = (ovf_q || quo_q > 32'h80000000) ? 32'h80000000 : -quo_q;
    else       res_v = (ovf_q || quo_q[31]) ? 32'h7FFFFFFF : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      prev_r_q  <= '0;
      prev_l_q  <= '0;
      prev_t_q  <= '0;
      head_q    <= '0;
      acc_x_q   <= '0;
      acc_y_q   <= '0;
    end else begin
      case (cmd_i.op)
        dd_odom_pkg::OP_FIRST: begin
          started_q <= 1'b1;
          prev_r_q  <= r_q;
          prev_l_q  <= l_q;
          prev_t_q  <= t_q;
        end
        dd_odom_pkg::OP_DELTA: begin
          prev_r_q <= r_q;
          prev_l_q <= l_q;
          prev_t_q <= t_q;
        end
        dd_odom_pkg::OP_HEAD: head_q  <= head_q + dth_q[31:0];
        dd_odom_pkg::OP_PX:   acc_x_q <= acc_x_q + pshift_v[47:0];
        dd_odom_pkg::OP_PY:   acc_y_q <= acc_y_q + pshift_v[47:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      dd_odom_pkg::OP_LOAD: begin
        r_q <= cfg_i.invert_right ? -in_data_i.raw_right : in_data_i.raw_right;
        l_q <= in_data_i.raw_left;
        t_q <= in_data_i.time_us;
      end
      dd_odom_pkg::OP_DELTA: begin
        dr_q <= r_q - prev_r_q;
        dl_q <= l_q - prev_l_q;
        dt_q <= t_q - prev_t_q;
      end
      dd_odom_pkg::OP_MUL: begin
        dist_q <= dist_v;
        dth_q  <= diff_v * $signed({1'b0, cfg_i.heading_per_tick});
      end
      dd_odom_pkg::OP_CINIT: begin
        cx_q   <= dd_odom_pkg::GAIN_Q30;
        cy_q   <= '0;
        cz_q   <= zi_v;
        flip_q <= fold_v;
      end
      dd_odom_pkg::OP_CSTEP: begin
        if (!cz_q[33]) begin
          cx_q <= cx_q - ys_v;
          cy_q <= cy_q + xs_v;
          cz_q <= cz_q - atan_v;
        end else begin
          cx_q <= cx_q + ys_v;
          cy_q <= cy_q - xs_v;
          cz_q <= cz_q + atan_v;
        end
      end
      dd_odom_pkg::OP_QUAT: begin
        qz_q <= qz_v;
        qw_q <= qw_v;
      end
      dd_odom_pkg::OP_PLO: begin
        mag_q  <= mag_v;
        neg_q  <= neg_v;
        prod_q <= {28'd0, 52'(mag_v[31:0]) * 52'(dd_odom_pkg::USEC)};
      end
      dd_odom_pkg::OP_PHI: begin
        prod_q <= prod_q +
                  {1'b0, 47'(mag_q[58:32]) * 47'(dd_odom_pkg::USEC), 32'd0};
      end
      dd_odom_pkg::OP_DINIT: begin
        // angular rate divides by dt * 2^16: drop 16 bits first
        num_q <= cmd_i.sel ? prod_q[79:16] : prod_q[63:0];
        rem_q <= '0;
        quo_q <= '0;
        ovf_q <= 1'b0;
      end
      dd_odom_pkg::OP_DSTEP: begin
        num_q <= {num_q[62:0], 1'b0};
        rem_q <= ge_v ? 32'(rem2_v - {1'b0, dt_q}) : rem2_v[31:0];
        quo_q <= {quo_q[30:0], ge_v};
        ovf_q <= ovf_q | quo_q[31];
      end
      dd_odom_pkg::OP_DFIN: begin
        if (cmd_i.sel) rate_q  <= res_v;
        else           speed_q <= res_v;
      end
      dd_odom_pkg::OP_OUT: begin
        out_q.pos_x <= (acc_x_q[47] && !(&acc_x_q[46:31])) ? 32'sh80000000 :
                       (!acc_x_q[47] && (|acc_x_q[46:31])) ? 32'sh7FFFFFFF :
                       acc_x_q[31:0];
        out_q.pos_y <= (acc_y_q[47] && !(&acc_y_q[46:31])) ? 32'sh80000000 :
                       (!acc_y_q[47] && (|acc_y_q[46:31])) ? 32'sh7FFFFFFF :
                       acc_y_q[31:0];
        out_q.heading      <= head_q;
        out_q.quat_z       <= qz_q;
        out_q.quat_w       <= qw_q;
        out_q.linear_speed <= speed_q;
        out_q.angular_rate <= rate_q;
        out_q.delta_right  <= dr_q;
        out_q.delta_left   <= dl_q;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/diff_drive_odometry_top.sv @@
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// Differential-drive wheel odometry with APB register port.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_stall_o/in_data_i) carries right and left
// encoder counts and a microsecond timestamp; output channel
// (out_valid_o/out_stall_i/out_data_o) carries pose, yaw quaternion, speeds
// and count deltas. A transaction moves when valid is high and stall low.
// Items are processed one at a time. The first item after reset only
// latches counts and time, and an item with no elapsed time is dropped;
// both free the input again once the check state returns to idle.
// Any other item gives one result after two CORDIC passes of one step a
// cycle (heading, then half heading) and two restoring divisions (speed,
// then angular rate).
// The result sits in an output register, so a new item can be accepted while
// the receiver stalls; the next result then waits until that one is taken.
// Reset clears the pose, the started flag and loads the default registers.
// Registers may be written only while the block is idle.
module diff_drive_odometry_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dd_odom_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dd_odom_pkg::out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  dd_odom_pkg::cfg_t  cfg_q;
  dd_odom_pkg::cmd_t  cmd;
  dd_odom_pkg::stat_t stat;

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.invert_right      <= 1'b1;
      cfg_q.dist_per_tick_q24 <= 24'd48943;
      cfg_q.heading_per_tick  <= 26'd6231530;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        dd_odom_pkg::REG_INVERT: cfg_q.invert_right      <= pwdata[0];
        dd_odom_pkg::REG_DIST:   cfg_q.dist_per_tick_q24 <= pwdata[23:0];
        dd_odom_pkg::REG_HEAD:   cfg_q.heading_per_tick  <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[3:2])
      dd_odom_pkg::REG_INVERT: prdata = {31'd0, cfg_q.invert_right};
      dd_odom_pkg::REG_DIST:   prdata = {8'd0, cfg_q.dist_per_tick_q24};
      dd_odom_pkg::REG_HEAD:   prdata = {6'd0, cfg_q.heading_per_tick};
      default:                 prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  dd_odom_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dd_odom_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

@@ hdl/dd_odom_checker.sv @@
// ----------------------------------------------------------------------------
// dd_odom_checker
// Port-level assertions for the odometry block, bound to the top level.
// ----------------------------------------------------------------------------
module dd_odom_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input dd_odom_pkg::out_t out_data_o,
  input logic              pready
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // block is busy right after taking a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  // register port never waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind diff_drive_odometry_top dd_odom_checker u_dd_odom_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wheel odometry block. A pose predictor in the
// bench tracks counts, time, heading and position and queues the expected
// pose per result-bearing input; a monitor compares each output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IDLE_CYCLES = 2 * dd_odom_pkg::CORDIC_STEPS + 200;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  dd_odom_pkg::in_t  in_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  dd_odom_pkg::out_t out_data_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  diff_drive_odometry_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // predictor state
  logic        started_q;
  logic [31:0] last_right, last_left, last_time, heading_q;
  logic [47:0] acc_x_q, acc_y_q;
  logic        inv_q;
  logic [23:0] dist_q;
  logic [25:0] head_q;

  dd_odom_pkg::out_t pose_queue[$];
  int     n_errors;
  bit     in_noise;     // sender idles at random
  bit     out_noise;    // receiver stalls at random
  int     hold_cycles;  // long receiver hold-off, counted by the stall process

  localparam logic signed [33:0] ATAN [24] = '{
    34'sh020000000, 34'sh012E4051E, 34'sh009FB385B, 34'sh0051111D4,
    34'sh0028B0D43, 34'sh00145D7E1, 34'sh000A2F61E, 34'sh000517C55,
    34'sh00028BE53, 34'sh000145F2F, 34'sh0000A2F98, 34'sh0000517CC,
    34'sh000028BE6, 34'sh0000145F3, 34'sh00000A2FA, 34'sh00000517D,
    34'sh0000028BE, 34'sh00000145F, 34'sh000000A30, 34'sh000000518,
    34'sh00000028C, 34'sh000000146, 34'sh0000000A3, 34'sh000000051};

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // arithmetic shift of a signed value floors, as wanted
  task automatic rotate(input logic [31:0] ang, output longint cs, output longint sn);
    longint z, x, y, t;
    bit     flip;
    z = longint'($signed(ang));
    x = dd_odom_pkg::GAIN_Q30;
    y = 0;
    flip = 0;
    if (z > 64'sh40000000) begin
      z -= 64'sh80000000; flip = 1;
    end else if (z < -64'sh40000000) begin
      z += 64'sh80000000; flip = 1;
    end
    for (int i = 0; i < dd_odom_pkg::CORDIC_STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN[i]);
      end
      x = t;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [15:0] q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // num * 1e6 / den toward zero, saturated; 128-bit product
  function automatic logic [31:0] rate_div(input longint num, input logic [63:0] den);
    logic [127:0] mag, q;
    mag = num < 0 ? 128'(-num) : 128'(num);
    q = (mag * 128'd1000000) / 128'(den);
    if (num < 0) return q > 128'h80000000 ? 32'h80000000 : 32'(-q);
    return q > 128'h7FFFFFFF ? 32'h7FFFFFFF : q[31:0];
  endfunction

  // advance the pose prediction by one input transaction
  task automatic predict_pose(input dd_odom_pkg::in_t it);
    logic [31:0]       r, dt, dr, dl;
    longint            sdr, sdl, travel, dth, c, s, hc, hs;
    dd_odom_pkg::out_t o;
    r = inv_q ? -it.raw_right : it.raw_right;
    if (!started_q) begin
      last_right = r; last_left = it.raw_left; last_time = it.time_us;
      started_q = 1;
      return;
    end
    dt = it.time_us - last_time;
    if (dt == 0) return;
    last_time = it.time_us;
    dr = r - last_right;
    dl = it.raw_left - last_left;
    last_right = r;
    last_left = it.raw_left;
    sdr = longint'($signed(dr));
    sdl = longint'($signed(dl));
    travel = sat32(((sdr + sdl) * longint'(dist_q) + 256) >>> 9);
    dth = (sdr - sdl) * longint'(head_q);
    heading_q = heading_q + dth[31:0];
    rotate(heading_q, c, s);
    acc_x_q = acc_x_q + 48'((travel * c + (64'sd1 <<< 29)) >>> 30);
    acc_y_q = acc_y_q + 48'((travel * s + (64'sd1 <<< 29)) >>> 30);
    rotate(heading_q >> 1, hc, hs);
    o.pos_x = 32'(sat32(longint'($signed(acc_x_q))));
    o.pos_y = 32'(sat32(longint'($signed(acc_y_q))));
    o.heading = heading_q;
    o.quat_z = q15(hs);
    o.quat_w = q15(hc);
    o.linear_speed = rate_div(travel, 64'(dt));
    o.angular_rate = rate_div(dth, 64'(dt) << 16);
    o.delta_right = dr;
    o.delta_left = dl;
    pose_queue.push_back(o);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    n_errors++;
  endtask

  // send one item; predicts on acceptance; valid stays up for the next one
  task automatic send_item(input dd_odom_pkg::in_t it);
    while (in_noise && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_pose(it);
  endtask

  // APB write and read-back, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] expv;
    in_valid_i <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    pwrite <= 0;
    penable <= 0;
    case (idx)
      dd_odom_pkg::REG_INVERT: begin
        inv_q = val[0];
        expv = {31'd0, val[0]};
      end
      dd_odom_pkg::REG_DIST: begin
        dist_q = val[23:0];
        expv = {8'd0, val[23:0]};
      end
      dd_odom_pkg::REG_HEAD: begin
        head_q = val[25:0];
        expv = {6'd0, val[25:0]};
      end
      default: expv = '0;
    endcase
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (prdata !== expv) report("read-back", 64'(prdata), 64'(expv));
    psel <= 0; penable <= 0;
  endtask

  // output monitor
  always @(posedge clk_i) begin
    dd_odom_pkg::out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pose_queue.size() == 0) begin
        report("unexpected result", 64'(out_data_o.heading), 0);
      end else begin
        e = pose_queue.pop_front();
        if (out_data_o.pos_x !== e.pos_x) report("pos_x", out_data_o.pos_x, e.pos_x);
        if (out_data_o.pos_y !== e.pos_y) report("pos_y", out_data_o.pos_y, e.pos_y);
        if (out_data_o.heading !== e.heading)
          report("heading", out_data_o.heading, e.heading);
        if (out_data_o.quat_z !== e.quat_z) report("quat_z", out_data_o.quat_z, e.quat_z);
        if (out_data_o.quat_w !== e.quat_w) report("quat_w", out_data_o.quat_w, e.quat_w);
        if (out_data_o.linear_speed !== e.linear_speed)
          report("linear_speed", out_data_o.linear_speed, e.linear_speed);
        if (out_data_o.angular_rate !== e.angular_rate)
          report("angular_rate", out_data_o.angular_rate, e.angular_rate);
        if (out_data_o.delta_right !== e.delta_right)
          report("delta_right", out_data_o.delta_right, e.delta_right);
        if (out_data_o.delta_left !== e.delta_left)
          report("delta_left", out_data_o.delta_left, e.delta_left);
      end
    end
  end

  // receiver stall: random, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= out_noise && ($urandom_range(99) < 30);
    end
  end

  function automatic dd_odom_pkg::in_t mk(input logic [31:0] r, input logic [31:0] l,
                                          input logic [31:0] t);
    dd_odom_pkg::in_t it;
    it.raw_right = r; it.raw_left = l; it.time_us = t;
    return it;
  endfunction

  // plausible motion with random content, plus occasional noise
  task automatic drive_random(input int n, input bit wild);
    logic [31:0] r, l, t;
    r = $urandom; l = $urandom; t = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin r = $urandom; l = $urandom; t = t + $urandom; end
        1: ; // repeated time stamp: dropped
        default: begin
          r = r + 32'($signed($urandom_range(4000)) - 2000);
          l = l + 32'($signed($urandom_range(4000)) - 2000);
          t = t + (wild ? $urandom : $urandom_range(100000, 1));
        end
      endcase
      send_item(mk(r, l, t));
    end
  endtask

  task automatic test_first_and_zero_dt();
    send_item(mk(32'd10, 32'd20, 32'd5));
    send_item(mk(32'd30, 32'd40, 32'd5));
    send_item(mk(32'd100, 32'd50, 32'd1005));
  endtask

  task automatic test_extremes();
    send_item(mk(32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFF0));
    send_item(mk(32'h80000000, 32'h7FFFFFFF, 32'h00000010));
    send_item(mk(32'hFFFFFFFF, 32'h00000000, 32'h00000011));
    send_item(mk(32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF));
    send_item(mk(32'h12345678, 32'hEDCBA987, 32'h0));
  endtask

  task automatic test_config_extremes();
    write_reg(dd_odom_pkg::REG_INVERT, 32'd0);
    write_reg(dd_odom_pkg::REG_DIST, 32'hFFFFFF);
    write_reg(dd_odom_pkg::REG_HEAD, 32'h3FFFFFF);
    test_extremes();
    drive_random(40, 1);
    write_reg(dd_odom_pkg::REG_DIST, 32'd1);
    write_reg(dd_odom_pkg::REG_HEAD, 32'd1);
    drive_random(40, 0);
    write_reg(dd_odom_pkg::REG_DIST, 32'd0);
    write_reg(dd_odom_pkg::REG_HEAD, 32'd0);
    drive_random(10, 0);
    write_reg(dd_odom_pkg::REG_INVERT, 32'd1);
    write_reg(dd_odom_pkg::REG_DIST, 32'd48943);
    write_reg(dd_odom_pkg::REG_HEAD, 32'd6231530);
  endtask

  task automatic test_backpressure();
    hold_cycles <= 3000;
    drive_random(30, 0);
  endtask

  task automatic test_random();
    in_noise = 0; out_noise = 0;
    drive_random(300, 0);
    in_noise = 1; out_noise = 1;
    for (int p = 0; p < 4; p++) begin
      write_reg(dd_odom_pkg::REG_INVERT, 32'($urandom_range(1)));
      write_reg(dd_odom_pkg::REG_DIST, 32'($urandom_range(24'hFFFFFF, 1)));
      write_reg(dd_odom_pkg::REG_HEAD, 32'($urandom_range(26'h3FFFFFF, 1)));
      drive_random(350, p[0]);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0; in_data_i = '0; out_stall_i = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    started_q = 0; last_right = 0; last_left = 0; last_time = 0;
    heading_q = 0; acc_x_q = 0; acc_y_q = 0;
    inv_q = 1; dist_q = 24'd48943; head_q = 26'd6231530;
    n_errors = 0; in_noise = 1; out_noise = 1; hold_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_and_zero_dt();
    test_extremes();
    test_config_extremes();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/dd_odom_pkg.sv
hdl/dd_odom_ctrl.sv
hdl/dd_odom_dp.sv
hdl/diff_drive_odometry_top.sv
hdl/dd_odom_checker.sv
bench/tb.sv
